// ===== sv/pcs_sel_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_sel_pkg: shared types and constants of the path cost selector
// Field widths, saturation limits and register indexes.
// ----------------------------------------------------------------------------
package pcs_sel_pkg;

  localparam int unsigned COORD_W   = 24;           // point and goal coordinates
  localparam int unsigned DIFF_W    = COORD_W + 1;  // coordinate differences
  localparam int unsigned LIMIT_W   = 23;           // distance limits
  localparam int unsigned ACC_W     = 2 * DIFF_W + 2;
  localparam int unsigned SQ_W      = 2 * DIFF_W;   // radicand of the root unit
  localparam int unsigned ROOT_W    = DIFF_W;
  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned CNT_W     = $clog2(ROOT_W);
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned PEN_W     = 12;
  localparam int unsigned COST_W    = 44;
  localparam int unsigned MUL_A_W   = 32;
  localparam int unsigned MUL_B_W   = 25;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned PTS_W     = $clog2(MAX_POINTS + 1);
  localparam int unsigned MAX_PATHS = 256;
  localparam int unsigned PATH_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [PEN_W-1:0]  PEN_MAX  = '1;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X    = 3'd0,
    REG_GOAL_Y    = 3'd1,
    REG_START_TOL = 3'd2,
    REG_NEAR      = 3'd3,
    REG_VERY_NEAR = 3'd4
  } cfg_reg_e;

  // magnitude of a signed difference, as an unsigned value of the same width
  function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] r;
    r = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
    return r;
  endfunction

  // signed difference a - b of two coordinates
  function automatic logic [DIFF_W-1:0] diff(input logic [COORD_W-1:0] a,
                                             input logic [COORD_W-1:0] b);
    logic [DIFF_W-1:0] r;
    r = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return r;
  endfunction

endpackage

// ===== sv/planned_path_cost_selector_core.sv =====
// ----------------------------------------------------------------------------
// planned_path_cost_selector_core
// Sums segment lengths of candidate paths, counts stretch penalties between
// cusps and keeps the first path of lowest cost in each set.
// ----------------------------------------------------------------------------
// The first point of a path is checked against the start tolerance, every
// further point adds its segment length and, at a cusp, a stretch penalty;
// the last point closes the final stretch before its result word is offered.
// One point in flight at a time. Throughput is set by the 25-step bit-serial
// square root and the single shared 32x25 multiplier. Async active-low reset
// loads register defaults and clears all path and set state; no clearing pass.
module planned_path_cost_selector_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration write channel
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i,
  // point stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,   // point_x, point_y
  input  logic          s_axis_tlast,   // end_of_path
  input  logic          s_axis_tuser,   // end_of_set
  // result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // path_number, path_cost, best_number, best_cost
  output logic          m_axis_tlast,   // set_done
  output logic          m_axis_tuser    // rejected
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_SQ_X, ST_SQ_Y, ST_SQ_SUM, ST_TOL_CMP,
    ST_ROOT, ST_ROOT_ACC, ST_DOT1, ST_DOT2, ST_DOT3,
    ST_NEAR_CMP, ST_VNEAR_CMP, ST_UPDATE, ST_END_CHK,
    ST_COST_MUL, ST_COST_SAT, ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    PUR_START, PUR_SEGMENT, PUR_STRETCH
  } purpose_e;

  localparam int unsigned CW = pcs_sel_pkg::COORD_W;
  localparam int unsigned DW = pcs_sel_pkg::DIFF_W;
  localparam int unsigned AW = pcs_sel_pkg::ACC_W;
  localparam int unsigned PW = pcs_sel_pkg::PROD_W;

  state_e   state_q;
  purpose_e purpose_q;

  // configuration
  logic [CW-1:0]                      goal_x_q, goal_y_q;
  logic [pcs_sel_pkg::LIMIT_W-1:0]    tol_q, near_q, vnear_q;

  // current point
  logic [CW-1:0] px_q, py_q;
  logic          eop_q, eos_q;

  // path state
  logic [CW-1:0]                   prev_x_q, prev_y_q, key_x_q, key_y_q;
  logic [DW-1:0]                   inc_dx_q, inc_dy_q;
  logic [DW-1:0]                   dx_q, dy_q, seg_dx_q, seg_dy_q;
  logic [pcs_sel_pkg::PTS_W-1:0]   pts_q;
  logic [pcs_sel_pkg::LEN_W-1:0]   len_q;
  logic [pcs_sel_pkg::PEN_W-1:0]   pen_q;
  logic                            too_far_q;
  logic                            stretch_end_q;
  logic                            near_hit_q;

  // set state
  logic [pcs_sel_pkg::PATH_W-1:0]  paths_q, best_idx_q;
  logic [pcs_sel_pkg::COST_W-1:0]  best_cost_q;
  logic [pcs_sel_pkg::COST_W-1:0]  cost_q;
  logic                            rej_q;

  // shared arithmetic
  logic [AW-1:0]                   acc_q;
  logic [PW-1:0]                   prod_q;
  logic                            neg1_q, neg2_q;

  // root unit
  logic [pcs_sel_pkg::SQ_W-1:0]    rad_q;
  logic [pcs_sel_pkg::REM_W-1:0]   rem_q;
  logic [pcs_sel_pkg::ROOT_W-1:0]  root_q;
  logic [pcs_sel_pkg::CNT_W-1:0]   cnt_q;

  // output register
  logic                            m_valid_q;
  logic [103:0]                    m_data_q;
  logic                            m_last_q, m_user_q;

  // -------------------------------------------------------------------------
  // combinational helpers
  // -------------------------------------------------------------------------
  logic [pcs_sel_pkg::MUL_A_W-1:0] mul_a;
  logic [pcs_sel_pkg::MUL_B_W-1:0] mul_b;
  logic [PW-1:0]                   mul_p;
  logic [AW-1:0]                   prod_lo, acc_sum, dot_sum;
  logic [PW-1:0]                   acc_ext;
  logic                            acc_lt_prod, acc_gt_prod;
  logic [DW-1:0]                   mag_dx, mag_dy, mag_idx, mag_idy;

  logic [pcs_sel_pkg::REM_W+1:0]   rem_sh, trial, rem_sub;
  logic                            root_bit;

  logic [pcs_sel_pkg::LEN_W:0]     len_sum;
  logic [1:0]                      pen_add;
  logic [pcs_sel_pkg::PEN_W:0]     pen_sum;
  logic                            new_best;
  logic [pcs_sel_pkg::COST_W-1:0]  best_cost_d;
  logic [pcs_sel_pkg::PATH_W-1:0]  best_idx_d;
  logic                            s_acc, out_free;

  assign mag_dx  = pcs_sel_pkg::mag(dx_q);
  assign mag_dy  = pcs_sel_pkg::mag(dy_q);
  assign mag_idx = pcs_sel_pkg::mag(inc_dx_q);
  assign mag_idy = pcs_sel_pkg::mag(inc_dy_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ_X: begin
        mul_a = pcs_sel_pkg::MUL_A_W'(mag_dx);
        mul_b = pcs_sel_pkg::MUL_B_W'(mag_dx);
      end
      ST_SQ_Y: begin
        mul_a = pcs_sel_pkg::MUL_A_W'(mag_dy);
        mul_b = pcs_sel_pkg::MUL_B_W'(mag_dy);
      end
      ST_SQ_SUM: begin
        if (purpose_q == PUR_START) begin
          mul_a = pcs_sel_pkg::MUL_A_W'(tol_q);
          mul_b = pcs_sel_pkg::MUL_B_W'(tol_q);
        end else begin
          mul_a = pcs_sel_pkg::MUL_A_W'(near_q);
          mul_b = pcs_sel_pkg::MUL_B_W'(near_q);
        end
      end
      ST_NEAR_CMP: begin
        mul_a = pcs_sel_pkg::MUL_A_W'(vnear_q);
        mul_b = pcs_sel_pkg::MUL_B_W'(vnear_q);
      end
      ST_DOT1: begin
        mul_a = pcs_sel_pkg::MUL_A_W'(mag_idx);
        mul_b = pcs_sel_pkg::MUL_B_W'(mag_dx);
      end
      ST_DOT2: begin
        mul_a = pcs_sel_pkg::MUL_A_W'(mag_idy);
        mul_b = pcs_sel_pkg::MUL_B_W'(mag_dy);
      end
      ST_COST_MUL: begin
        mul_a = len_q;
        mul_b = pcs_sel_pkg::MUL_B_W'(pen_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = PW'(mul_a) * PW'(mul_b);
  assign prod_lo = prod_q[AW-1:0];
  assign acc_sum = acc_q + prod_lo;
  assign dot_sum = acc_q + (neg2_q ? (~prod_lo + AW'(1)) : prod_lo);
  assign acc_ext = PW'(acc_q);
  assign acc_lt_prod = acc_ext < prod_q;
  assign acc_gt_prod = acc_ext > prod_q;

  // one result bit per cycle, two radicand bits shifted in
  assign rem_sh   = {rem_q, rad_q[pcs_sel_pkg::SQ_W-1 -: 2]};
  assign trial    = (pcs_sel_pkg::REM_W + 2)'({root_q, 2'b01});
  assign root_bit = rem_sh >= trial;
  assign rem_sub  = rem_sh - trial;

  assign len_sum = {1'b0, len_q} + (pcs_sel_pkg::LEN_W + 1)'(root_q);
  assign pen_add = 2'd1 + {1'b0, near_hit_q} + {1'b0, acc_lt_prod};
  assign pen_sum = {1'b0, pen_q} + (pcs_sel_pkg::PEN_W + 1)'(pen_add);

  assign new_best    = cost_q < best_cost_q;
  assign best_cost_d = new_best ? cost_q : best_cost_q;
  assign best_idx_d  = new_best ? paths_q : best_idx_q;

  assign s_acc    = s_axis_tvalid && (state_q == ST_IDLE);
  assign out_free = !m_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

  // -------------------------------------------------------------------------
  // sequencer and datapath registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      purpose_q     <= PUR_START;
      goal_x_q      <= '0;
      goal_y_q      <= '0;
      tol_q         <= pcs_sel_pkg::LIMIT_W'(768);
      near_q        <= pcs_sel_pkg::LIMIT_W'(2560);
      vnear_q       <= pcs_sel_pkg::LIMIT_W'(1280);
      px_q          <= '0;
      py_q          <= '0;
      eop_q         <= 1'b0;
      eos_q         <= 1'b0;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      key_x_q       <= '0;
      key_y_q       <= '0;
      inc_dx_q      <= '0;
      inc_dy_q      <= '0;
      dx_q          <= '0;
      dy_q          <= '0;
      seg_dx_q      <= '0;
      seg_dy_q      <= '0;
      pts_q         <= '0;
      len_q         <= '0;
      pen_q         <= '0;
      too_far_q     <= 1'b0;
      stretch_end_q <= 1'b0;
      near_hit_q    <= 1'b0;
      paths_q       <= '0;
      best_idx_q    <= '0;
      best_cost_q   <= pcs_sel_pkg::COST_MAX;
      cost_q        <= '0;
      rej_q         <= 1'b0;
      acc_q         <= '0;
      prod_q        <= '0;
      neg1_q        <= 1'b0;
      neg2_q        <= 1'b0;
      rad_q         <= '0;
      rem_q         <= '0;
      root_q        <= '0;
      cnt_q         <= '0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      m_last_q      <= 1'b0;
      m_user_q      <= 1'b0;
    end else begin
      prod_q <= mul_p;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          pcs_sel_pkg::REG_GOAL_X:    goal_x_q <= cfg_data_i;
          pcs_sel_pkg::REG_GOAL_Y:    goal_y_q <= cfg_data_i;
          pcs_sel_pkg::REG_START_TOL: tol_q    <= cfg_data_i[pcs_sel_pkg::LIMIT_W-1:0];
          pcs_sel_pkg::REG_NEAR:      near_q   <= cfg_data_i[pcs_sel_pkg::LIMIT_W-1:0];
          pcs_sel_pkg::REG_VERY_NEAR: vnear_q  <= cfg_data_i[pcs_sel_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            px_q    <= s_axis_tdata[CW-1:0];
            py_q    <= s_axis_tdata[2*CW-1:CW];
            eop_q   <= s_axis_tlast;
            eos_q   <= s_axis_tuser;
            state_q <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          if (pts_q == '0) begin
            dx_q      <= pcs_sel_pkg::diff(px_q, goal_x_q);
            dy_q      <= pcs_sel_pkg::diff(py_q, goal_y_q);
            purpose_q <= PUR_START;
          end else begin
            dx_q      <= pcs_sel_pkg::diff(px_q, prev_x_q);
            dy_q      <= pcs_sel_pkg::diff(py_q, prev_y_q);
            seg_dx_q  <= pcs_sel_pkg::diff(px_q, prev_x_q);
            seg_dy_q  <= pcs_sel_pkg::diff(py_q, prev_y_q);
            purpose_q <= PUR_SEGMENT;
          end
          state_q <= ST_SQ_X;
        end
        ST_SQ_X: state_q <= ST_SQ_Y;
        ST_SQ_Y: begin
          acc_q   <= prod_lo;
          state_q <= ST_SQ_SUM;
        end
        ST_SQ_SUM: begin
          // squared distance settles here; limit square is issued alongside
          acc_q <= acc_sum;
          case (purpose_q)
            PUR_START:   state_q <= ST_TOL_CMP;
            PUR_SEGMENT: begin
              rad_q   <= acc_sum[pcs_sel_pkg::SQ_W-1:0];
              rem_q   <= '0;
              root_q  <= '0;
              cnt_q   <= '0;
              state_q <= ST_ROOT;
            end
            default:     state_q <= ST_NEAR_CMP;
          endcase
        end
        ST_TOL_CMP: begin
          too_far_q <= acc_gt_prod;
          key_x_q   <= px_q;
          key_y_q   <= py_q;
          len_q     <= '0;
          pen_q     <= '0;
          state_q   <= ST_UPDATE;
        end
        ST_ROOT: begin
          rad_q  <= rad_q << 2;
          rem_q  <= root_bit ? rem_sub[pcs_sel_pkg::REM_W-1:0]
                             : rem_sh[pcs_sel_pkg::REM_W-1:0];
          root_q <= {root_q[pcs_sel_pkg::ROOT_W-2:0], root_bit};
          cnt_q  <= cnt_q + pcs_sel_pkg::CNT_W'(1);
          if (cnt_q == pcs_sel_pkg::CNT_W'(pcs_sel_pkg::ROOT_W - 1)) begin
            state_q <= ST_ROOT_ACC;
          end
        end
        ST_ROOT_ACC: begin
          len_q   <= len_sum[pcs_sel_pkg::LEN_W] ? pcs_sel_pkg::LEN_MAX
                                                 : len_sum[pcs_sel_pkg::LEN_W-1:0];
          dx_q    <= seg_dx_q;
          dy_q    <= seg_dy_q;
          state_q <= ST_DOT1;
        end
        ST_DOT1: begin
          neg1_q  <= inc_dx_q[DW-1] ^ dx_q[DW-1];
          state_q <= ST_DOT2;
        end
        ST_DOT2: begin
          acc_q   <= neg1_q ? (~prod_lo + AW'(1)) : prod_lo;
          neg2_q  <= inc_dy_q[DW-1] ^ dy_q[DW-1];
          state_q <= ST_DOT3;
        end
        ST_DOT3: begin
          inc_dx_q <= seg_dx_q;
          inc_dy_q <= seg_dy_q;
          // cusp at the previous point: close the stretch from the key point
          if (pts_q >= pcs_sel_pkg::PTS_W'(2) && dot_sum[AW-1]) begin
            dx_q          <= pcs_sel_pkg::diff(prev_x_q, key_x_q);
            dy_q          <= pcs_sel_pkg::diff(prev_y_q, key_y_q);
            purpose_q     <= PUR_STRETCH;
            stretch_end_q <= 1'b0;
            state_q       <= ST_SQ_X;
          end else begin
            state_q <= ST_UPDATE;
          end
        end
        ST_NEAR_CMP: begin
          near_hit_q <= acc_lt_prod;
          state_q    <= ST_VNEAR_CMP;
        end
        ST_VNEAR_CMP: begin
          pen_q <= pen_sum[pcs_sel_pkg::PEN_W] ? pcs_sel_pkg::PEN_MAX
                                               : pen_sum[pcs_sel_pkg::PEN_W-1:0];
          if (stretch_end_q) begin
            state_q <= ST_COST_MUL;
          end else begin
            key_x_q <= prev_x_q;
            key_y_q <= prev_y_q;
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          prev_x_q <= px_q;
          prev_y_q <= py_q;
          if (pts_q < pcs_sel_pkg::PTS_W'(pcs_sel_pkg::MAX_POINTS)) begin
            pts_q <= pts_q + pcs_sel_pkg::PTS_W'(1);
          end
          state_q <= eop_q ? ST_END_CHK : ST_IDLE;
        end
        ST_END_CHK: begin
          if (pts_q < pcs_sel_pkg::PTS_W'(2) || too_far_q) begin
            rej_q   <= 1'b1;
            cost_q  <= pcs_sel_pkg::COST_MAX;
            state_q <= ST_RESULT;
          end else begin
            rej_q         <= 1'b0;
            dx_q          <= pcs_sel_pkg::diff(px_q, key_x_q);
            dy_q          <= pcs_sel_pkg::diff(py_q, key_y_q);
            purpose_q     <= PUR_STRETCH;
            stretch_end_q <= 1'b1;
            state_q       <= ST_SQ_X;
          end
        end
        ST_COST_MUL: state_q <= ST_COST_SAT;
        ST_COST_SAT: begin
          cost_q  <= (prod_q > PW'(pcs_sel_pkg::COST_MAX)) ? pcs_sel_pkg::COST_MAX
                                                          : prod_q[pcs_sel_pkg::COST_W-1:0];
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {best_cost_d, best_idx_d, cost_q, paths_q};
            m_last_q  <= eos_q;
            m_user_q  <= rej_q;
            prev_x_q  <= '0;
            prev_y_q  <= '0;
            inc_dx_q  <= '0;
            inc_dy_q  <= '0;
            key_x_q   <= '0;
            key_y_q   <= '0;
            pts_q     <= '0;
            len_q     <= '0;
            pen_q     <= '0;
            too_far_q <= 1'b0;
            if (eos_q) begin
              paths_q     <= '0;
              best_cost_q <= pcs_sel_pkg::COST_MAX;
              best_idx_q  <= '0;
            end else begin
              best_cost_q <= best_cost_d;
              best_idx_q  <= best_idx_d;
              if (paths_q == pcs_sel_pkg::PATH_W'(pcs_sel_pkg::MAX_PATHS - 1)) begin
                paths_q <= '0;
              end else begin
                paths_q <= paths_q + pcs_sel_pkg::PATH_W'(1);
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
